// File: rtl/tlps_pkg.sv
`default_nettype none

package tlps_pkg;

    // Fixed field widths
    localparam int PHASE_W = 3;
    localparam int TIME_W  = 16;
    localparam int ROAD_W  = 8;
    localparam int LANE_W  = 4;
    localparam int ELAP_W  = 32;

    // Colour codes
    localparam logic [1:0] COL_GREEN  = 2'd0;
    localparam logic [1:0] COL_ORANGE = 2'd1;
    localparam logic [1:0] COL_RED    = 2'd2;

    // Item operations
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_QUERY  = 2'd1,
        OP_TIMING = 2'd2,
        OP_ADD    = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic CFG_PHASE_COUNT = 1'b0;
    localparam logic CFG_TICK_STEP   = 1'b1;

    // One phase memory entry: durations plus the stored colour
    typedef struct packed {
        logic [TIME_W-1:0] green;
        logic [TIME_W-1:0] orange;
        logic [TIME_W-1:0] red;
        logic [1:0]        colour;
    } phase_entry_t;

    localparam phase_entry_t PHASE_RESET = '{
        green:  '0,
        orange: '0,
        red:    '0,
        colour: COL_RED
    };

    // One connection table entry
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [ROAD_W-1:0]  from_road;
        logic [LANE_W-1:0]  from_lane;
        logic [ROAD_W-1:0]  to_road;
        logic [LANE_W-1:0]  to_lane;
    } conn_entry_t;

endpackage

`default_nettype wire

// File: rtl/traffic_light_phase_sequencer_top.sv
`default_nettype none

// Sequence: tick and timing write pass PEXEC, CRD, CFIN and DONE; connection add
// passes CFIN and DONE; query scans entries in SCAN until a match or the end, then DONE.
// Throughput: one item at a time; the next item is taken once the result is in
// the output register. Reset clears counters and phase written flags and sets both
// config registers to one; phases read as zero timing and red. No clearing pass.
module traffic_light_phase_sequencer_top
    import tlps_pkg::*;
#(
    parameter int MAX_PHASES      = 8,
    parameter int MAX_CONNECTIONS = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    // input items
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic [PHASE_W-1:0] phase,
    input  wire logic [TIME_W-1:0]  green_time,
    input  wire logic [TIME_W-1:0]  orange_time,
    input  wire logic [TIME_W-1:0]  red_time,
    input  wire logic [ROAD_W-1:0]  from_road,
    input  wire logic [LANE_W-1:0]  from_lane,
    input  wire logic [ROAD_W-1:0]  to_road,
    input  wire logic [LANE_W-1:0]  to_lane,
    // result items
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              light_colour,
    output logic [PHASE_W-1:0]      active_phase,
    output logic                    table_full
);

    localparam int PH_DEPTH = (MAX_PHASES < 8) ? MAX_PHASES : 8;
    localparam int CNTW     = $clog2(MAX_CONNECTIONS + 1);
    localparam int IDXW     = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
    localparam logic [6:0]      MAXP7   = 7'(MAX_PHASES);
    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_CONNECTIONS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PEXEC = 6'b000010,
        ST_CRD   = 6'b000100,
        ST_CFIN  = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Config
    logic [3:0]  phase_count_reg;
    logic [15:0] tick_step_reg;

    // Sequencer state
    logic [ELAP_W-1:0]  elapsed_reg, elapsed_next;
    logic [PHASE_W-1:0] cur_reg, cur_next;
    logic [CNTW-1:0]    conn_count_reg, conn_count_next;
    logic [CNTW-1:0]    scan_idx_reg, scan_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [1:0]         res_colour_reg, res_colour_next;
    logic               res_full_reg, res_full_next;

    // Captured item
    op_t                op_reg;
    logic [PHASE_W-1:0] ph_reg;
    logic               ph_ok_reg;
    logic [TIME_W-1:0]  green_reg, orange_reg, red_reg;
    logic [ROAD_W-1:0]  from_road_reg, to_road_reg;
    logic [LANE_W-1:0]  from_lane_reg, to_lane_reg;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         light_colour_reg;
    logic [PHASE_W-1:0] active_phase_reg;
    logic               table_full_reg;

    // Memory ports
    logic               pm_rd_en, pm_wr_en;
    logic [PHASE_W-1:0] pm_rd_addr, pm_wr_addr;
    phase_entry_t       pm_wr_data, pm_rd_data;
    logic               cm_wr_en, cm_rd_en;
    logic [IDXW-1:0]    cm_wr_addr, cm_rd_addr;
    conn_entry_t        cm_wr_data, cm_rd_data;

    logic accept, out_load;
    logic p_ok, cur_ok;
    logic [ELAP_W:0]    sum33;
    logic [ELAP_W-1:0]  elapsed_sat;
    logic [TIME_W:0]    go17;
    logic [TIME_W+1:0]  tot18;
    logic gt_g, gt_go, gt_tot, tick_adv;
    logic [1:0] tick_colour;
    logic [6:0] eff7, nx7;
    logic [PHASE_W-1:0] nx_phase;
    logic match;

    tlps_phase_mem #(
        .DEPTH (PH_DEPTH)
    ) u_phase_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pm_rd_en),
        .rd_addr (pm_rd_addr),
        .wr_en   (pm_wr_en),
        .wr_addr (pm_wr_addr),
        .wr_data (pm_wr_data),
        .rd_data (pm_rd_data)
    );

    tlps_conn_mem #(
        .DEPTH (MAX_CONNECTIONS),
        .IDXW  (IDXW)
    ) u_conn_mem (
        .clk     (clk),
        .wr_en   (cm_wr_en),
        .wr_addr (cm_wr_addr),
        .wr_data (cm_wr_data),
        .rd_en   (cm_rd_en),
        .rd_addr (cm_rd_addr),
        .rd_data (cm_rd_data)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign p_ok   = {4'b0, phase} < MAXP7;
    assign cur_ok = {4'b0, cur_reg} < MAXP7;

    // Saturating elapsed update
    assign sum33       = {1'b0, elapsed_reg} + {17'b0, tick_step_reg};
    assign elapsed_sat = sum33[ELAP_W] ? '1 : sum33[ELAP_W-1:0];

    // Colour thresholds of the current phase
    assign go17   = {1'b0, pm_rd_data.green} + {1'b0, pm_rd_data.orange};
    assign tot18  = {1'b0, go17} + {2'b0, pm_rd_data.red};
    assign gt_g   = elapsed_reg > {16'b0, pm_rd_data.green};
    assign gt_go  = elapsed_reg > {15'b0, go17};
    assign gt_tot = elapsed_reg > {14'b0, tot18};
    assign tick_colour = !gt_g ? COL_GREEN : (gt_go ? COL_RED : COL_ORANGE);
    assign tick_adv    = cur_ok && gt_go && gt_tot;

    // Next phase, wrapping at the effective phase count
    always_comb
    begin
        eff7 = {3'b0, phase_count_reg};
        if (eff7 == 7'd0)
        begin
            eff7 = 7'd1;
        end
        if (eff7 > MAXP7)
        begin
            eff7 = MAXP7;
        end
        nx7      = {4'b0, cur_reg} + 7'd1;
        nx_phase = (nx7 >= eff7) ? '0 : nx7[PHASE_W-1:0];
    end

    // Connection compare against the captured query
    assign match = cmp_valid_reg
                && (cm_rd_data.phase == ph_reg)
                && (cm_rd_data.from_road == from_road_reg)
                && (cm_rd_data.from_lane == from_lane_reg)
                && (cm_rd_data.to_road == to_road_reg)
                && (cm_rd_data.to_lane == to_lane_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        elapsed_next    = elapsed_reg;
        cur_next        = cur_reg;
        conn_count_next = conn_count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = 1'b0;
        res_colour_next = res_colour_reg;
        res_full_next   = res_full_reg;

        pm_rd_en   = 1'b0;
        pm_rd_addr = cur_reg;
        pm_wr_en   = 1'b0;
        pm_wr_addr = cur_reg;
        pm_wr_data = pm_rd_data;
        cm_wr_en   = 1'b0;
        cm_wr_addr = conn_count_reg[IDXW-1:0];
        cm_wr_data = '{phase: phase, from_road: from_road, from_lane: from_lane,
                       to_road: to_road, to_lane: to_lane};
        cm_rd_en   = 1'b0;
        cm_rd_addr = scan_idx_reg[IDXW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_full_next = 1'b0;
                    unique case (op_t'(op))
                        OP_TICK:
                        begin
                            elapsed_next = elapsed_sat;
                            pm_rd_en     = 1'b1;
                            pm_rd_addr   = cur_reg;
                            state_next   = ST_PEXEC;
                        end
                        OP_QUERY:
                        begin
                            pm_rd_en      = p_ok;
                            pm_rd_addr    = phase;
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        OP_TIMING:
                        begin
                            pm_rd_en   = 1'b1;
                            pm_rd_addr = phase;
                            state_next = ST_PEXEC;
                        end
                        OP_ADD:
                        begin
                            if (p_ok)
                            begin
                                if (conn_count_reg < CNT_MAX)
                                begin
                                    cm_wr_en        = 1'b1;
                                    conn_count_next = conn_count_reg + 1'b1;
                                end
                                else
                                begin
                                    res_full_next = 1'b1;
                                end
                            end
                            pm_rd_en   = 1'b1;
                            pm_rd_addr = cur_reg;
                            state_next = ST_CFIN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PEXEC:
            begin
                // read-modify-write of one phase entry
                if (op_reg == OP_TICK)
                begin
                    if (cur_ok)
                    begin
                        pm_wr_en          = 1'b1;
                        pm_wr_addr        = cur_reg;
                        pm_wr_data.colour = tick_colour;
                    end
                    if (tick_adv)
                    begin
                        elapsed_next = '0;
                        cur_next     = nx_phase;
                    end
                end
                else if (ph_ok_reg)
                begin
                    pm_wr_en          = 1'b1;
                    pm_wr_addr        = ph_reg;
                    pm_wr_data.green  = green_reg;
                    pm_wr_data.orange = orange_reg;
                    pm_wr_data.red    = red_reg;
                end
                state_next = ST_CRD;
            end
            ST_CRD:
            begin
                pm_rd_en   = 1'b1;
                pm_rd_addr = cur_reg;
                state_next = ST_CFIN;
            end
            ST_CFIN:
            begin
                res_colour_next = cur_ok ? pm_rd_data.colour : COL_RED;
                state_next      = ST_DONE;
            end
            ST_SCAN:
            begin
                if (!ph_ok_reg)
                begin
                    res_colour_next = COL_RED;
                    state_next      = ST_DONE;
                end
                else if (match)
                begin
                    res_colour_next = pm_rd_data.colour;
                    state_next      = ST_DONE;
                end
                else if (scan_idx_reg < conn_count_reg)
                begin
                    cm_rd_en       = 1'b1;
                    scan_idx_next  = scan_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    res_colour_next = COL_RED;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_count_reg <= 4'd1;
            tick_step_reg   <= 16'd1;
            elapsed_reg     <= '0;
            cur_reg         <= '0;
            conn_count_reg  <= '0;
            scan_idx_reg    <= '0;
            cmp_valid_reg   <= 1'b0;
            res_colour_reg  <= COL_RED;
            res_full_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            elapsed_reg    <= elapsed_next;
            cur_reg        <= cur_next;
            conn_count_reg <= conn_count_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            res_colour_reg <= res_colour_next;
            res_full_reg   <= res_full_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PHASE_COUNT: phase_count_reg <= cfg_wdata[3:0];
                    CFG_TICK_STEP:   tick_step_reg   <= cfg_wdata;
                    default:         tick_step_reg   <= tick_step_reg;
                endcase
            end
        end
    end

    // Item capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op_t'(op);
            ph_reg        <= phase;
            ph_ok_reg     <= p_ok;
            green_reg     <= green_time;
            orange_reg    <= orange_time;
            red_reg       <= red_time;
            from_road_reg <= from_road;
            from_lane_reg <= from_lane;
            to_road_reg   <= to_road;
            to_lane_reg   <= to_lane;
        end
        if (out_load)
        begin
            light_colour_reg <= res_colour_reg;
            active_phase_reg <= cur_reg;
            table_full_reg   <= res_full_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign light_colour = light_colour_reg;
    assign active_phase = active_phase_reg;
    assign table_full   = table_full_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        conn_count_reg <= CNT_MAX)
        else $error("connection count beyond table depth");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_full_reg) |-> (conn_count_reg == CNT_MAX))
        else $error("table full reported with free slots");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {4'b0, cur_reg} < MAXP7)
        else $error("current phase out of range");

    a_advance_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PEXEC && op_reg == OP_TICK && tick_adv) |=> (elapsed_reg == '0))
        else $error("elapsed counter not cleared on phase advance");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= conn_count_reg))
        else $error("scan index past table fill");

endmodule

`default_nettype wire

// File: rtl/tlps_phase_mem.sv
`default_nettype none

// Per-phase timing and colour store, one read and one write port,
// registered read. Entries not yet written read as zero timing, red.
module tlps_phase_mem
    import tlps_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rd_en,
    input  wire logic [PHASE_W-1:0] rd_addr,
    input  wire logic               wr_en,
    input  wire logic [PHASE_W-1:0] wr_addr,
    input  wire phase_entry_t       wr_data,
    output phase_entry_t            rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PHASE_W:0] DEPTH_C = (PHASE_W+1)'(DEPTH);

    phase_entry_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    phase_entry_t rd_raw_reg;
    logic rd_vld_reg;

    logic rd_in_rng;
    logic wr_in_rng;
    logic [AW-1:0] ra;
    logic [AW-1:0] wa;

    assign rd_in_rng = {1'b0, rd_addr} < DEPTH_C;
    assign wr_in_rng = {1'b0, wr_addr} < DEPTH_C;
    assign ra = rd_addr[AW-1:0];
    assign wa = wr_addr[AW-1:0];

    // Storage and read data
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_rng)
        begin
            mem[wa] <= wr_data;
        end
        if (rd_en && rd_in_rng)
        begin
            rd_raw_reg <= mem[ra];
        end
    end

    // Written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_rng)
            begin
                valid_reg[wa] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= rd_in_rng && valid_reg[ra];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : PHASE_RESET;

endmodule

`default_nettype wire

// File: rtl/tlps_conn_mem.sv
`default_nettype none

// Connection table: one write port, one registered read port.
module tlps_conn_mem
    import tlps_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDXW  = 6
)
(
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [IDXW-1:0] wr_addr,
    input  wire conn_entry_t     wr_data,
    input  wire logic            rd_en,
    input  wire logic [IDXW-1:0] rd_addr,
    output conn_entry_t          rd_data
);

    conn_entry_t mem [DEPTH];
    conn_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
